// ===== rtl/swrw_pkg.sv =====
// Shared types and constants for the sliding window row whitener.
// Used by the controller, the datapath and the top level.
package swrw_pkg;

    localparam int SAMPLE_W  = 16;
    localparam int CNT_W     = 7;
    localparam int ADDR_W    = 6;
    localparam int BUF_DEPTH = 64;
    localparam int WIN_W     = 6;
    localparam int BURST_W   = 6;
    localparam int MAX_BURST = 32;
    localparam int S_W       = 22;
    localparam int Q_W       = 38;
    localparam int D_W       = 44;
    localparam int QUO_W     = 32;
    localparam int ROOT_W    = 16;
    localparam int REM_W     = 18;
    localparam int IT_W      = 5;

    localparam logic [CNT_W-1:0] WRAP_AT  = 7'd96;
    localparam logic [CNT_W-1:0] WRAP_SUB = 7'd64;
    localparam logic [IT_W-1:0]  DIV_LAST = 5'd31;
    localparam logic [IT_W-1:0]  SQ_LAST  = 5'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_RAW,
        ST_INIT,
        ST_ACC,
        ST_DRAIN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_DIV0,
        ST_DIV,
        ST_SQRT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic accept;
        logic clear_row;
        logic raw_load;
        logic frame_init;
        logic acc_step;
        logic drain;
        logic mul1;
        logic mul2;
        logic mul3;
        logic div_init;
        logic div_step;
        logic sqrt_step;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic more;
        logic bypass;
        logic last_row;
        logic acc_last;
        logic early;
        logic it_done_div;
        logic it_done_sq;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/swrw_ctrl.sv =====
// Sequencer of the row whitener: walks each frame through window sums, products and, unless
// it exits early, the long division and the square root; bypass frames are copied raw. Depends on swrw_pkg.
module swrw_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  swrw_pkg::sts_t sts,
    output swrw_pkg::cmd_t cmd
);
    import swrw_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (sts.more) begin
                    state_next = sts.bypass ? ST_RAW : ST_INIT;
                end else begin
                    cmd.clear_row = sts.last_row;
                    state_next    = ST_IDLE;
                end
            end
            ST_RAW: begin
                cmd.raw_load = 1'b1;
                state_next   = ST_EMIT;
            end
            ST_INIT: begin
                cmd.frame_init = 1'b1;
                state_next     = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc_step = 1'b1;
                if (sts.acc_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.drain  = 1'b1;
                state_next = ST_MUL1;
            end
            ST_MUL1: begin
                cmd.mul1   = 1'b1;
                state_next = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2   = 1'b1;
                state_next = ST_MUL3;
            end
            ST_MUL3: begin
                cmd.mul3   = 1'b1;
                state_next = ST_DIV0;
            end
            ST_DIV0: begin
                cmd.div_init = 1'b1;
                state_next   = sts.early ? ST_EMIT : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (sts.it_done_div) begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (sts.it_done_sq) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== rtl/swrw_dp.sv =====
// Datapath of the row whitener: sample buffer, row counters, window sums,
// products, restoring divider, digit square root and output register.
// Depends on swrw_pkg; driven by swrw_ctrl.
module swrw_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [swrw_pkg::WIN_W-1:0]    window_len,
    input  logic [swrw_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                          in_last,
    input  swrw_pkg::cmd_t                cmd,
    output swrw_pkg::sts_t                sts,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [swrw_pkg::SAMPLE_W-1:0] out_data,
    output logic                          out_last
);
    import swrw_pkg::*;

    logic [SAMPLE_W-1:0] mem [BUF_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;
    logic [ADDR_W-1:0]   rd_addr;

    logic [CNT_W-1:0]   rcv_reg, emt_reg, t_reg, end_reg;
    logic [CNT_W-1:0]   rcv_adj, emt_adj, limit, half7;
    logic               last_reg, pend_reg, zero_reg;
    logic [BURST_W-1:0] cnt_reg;
    logic [WIN_W-1:0]   n_reg;
    logic [S_W-1:0]     s_reg, nx_reg, num_reg;
    logic [Q_W-1:0]     q_reg;
    logic [D_W-1:0]     nq_reg, ss_reg, d_reg, sq_reg, r_reg;
    logic [QUO_W-1:0]   quo_reg, low_reg;
    logic [IT_W-1:0]    it_reg;
    logic [ROOT_W-1:0]  root_reg, res_reg;
    logic [REM_W-1:0]   rem_reg;
    logic               out_valid_reg, out_last_reg;
    logic [SAMPLE_W-1:0] out_data_reg;

    logic               bypass;
    logic [WIN_W-2:0]   half;
    logic [CNT_W:0]     win_end, win_start;
    logic [D_W:0]       r_shift, r_sub;
    logic               r_ge;
    logic [REM_W+1:0]   rem4, trial, rem_sub;
    logic               sq_ge;
    logic [ROOT_W-1:0]  root_new;

    assign bypass = (window_len <= WIN_W'(1));
    assign half   = bypass ? '0 : window_len[WIN_W-1:1];
    assign half7  = CNT_W'(half);

    assign emt_adj = (emt_reg >= WRAP_AT) ? emt_reg - WRAP_SUB : emt_reg;
    assign rcv_adj = (emt_reg >= WRAP_AT) ? rcv_reg - WRAP_SUB : rcv_reg;

    assign limit = last_reg ? rcv_reg : ((rcv_reg > half7) ? rcv_reg - half7 : '0);

    // Window of the frame at emt_reg, cut at the row edges.
    assign win_start = (emt_reg > half7) ? {1'b0, emt_reg - half7} : '0;
    assign win_end   = ({1'b0, emt_reg} + {1'b0, half7} + 8'd1 > {1'b0, rcv_reg})
                       ? {1'b0, rcv_reg} : {1'b0, emt_reg} + {1'b0, half7} + 8'd1;

    assign rd_addr = cmd.acc_step ? t_reg[ADDR_W-1:0] : emt_reg[ADDR_W-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mem[rcv_adj[ADDR_W-1:0]] <= in_sample;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Restoring division step and square root digit step.
    assign r_shift = {r_reg, low_reg[QUO_W-1]};
    assign r_ge    = (r_shift >= {1'b0, d_reg});
    assign r_sub   = r_shift - {1'b0, d_reg};
    assign rem4    = {rem_reg, quo_reg[QUO_W-1:QUO_W-2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign sq_ge   = (rem4 >= trial);
    assign rem_sub = rem4 - trial;
    assign root_new = {root_reg[ROOT_W-2:0], sq_ge};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rcv_reg       <= '0;
            emt_reg       <= '0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.accept) begin
                rcv_reg  <= rcv_adj + CNT_W'(1);
                emt_reg  <= emt_adj;
                last_reg <= in_last;
                cnt_reg  <= '0;
            end
            if (cmd.clear_row) begin
                rcv_reg <= '0;
                emt_reg <= '0;
            end
            if (cmd.emit) begin
                emt_reg       <= emt_reg + CNT_W'(1);
                cnt_reg       <= cnt_reg + BURST_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= res_reg;
            out_last_reg <= last_reg && (emt_reg + CNT_W'(1) == rcv_reg);
        end
        if (cmd.raw_load) begin
            res_reg <= rd_data_reg;
        end
        if (cmd.frame_init) begin
            t_reg    <= win_start[CNT_W-1:0];
            end_reg  <= win_end[CNT_W-1:0];
            n_reg    <= WIN_W'(win_end - win_start);
            s_reg    <= '0;
            q_reg    <= '0;
            pend_reg <= 1'b0;
        end
        if (cmd.acc_step || cmd.drain) begin
            if (pend_reg) begin
                s_reg <= s_reg + S_W'(rd_data_reg);
                q_reg <= q_reg + Q_W'(rd_data_reg) * Q_W'(rd_data_reg);
            end
            pend_reg <= cmd.acc_step;
        end
        if (cmd.acc_step) begin
            t_reg <= t_reg + CNT_W'(1);
        end
        if (cmd.mul1) begin
            nx_reg <= S_W'(n_reg) * S_W'(rd_data_reg);
            nq_reg <= D_W'(n_reg) * D_W'(q_reg);
            ss_reg <= D_W'(s_reg) * D_W'(s_reg);
        end
        if (cmd.mul2) begin
            zero_reg <= (nx_reg <= s_reg);
            num_reg  <= nx_reg - s_reg;
            d_reg    <= nq_reg - ss_reg;
        end
        if (cmd.mul3) begin
            sq_reg <= D_W'(num_reg) * D_W'(num_reg);
        end
        if (cmd.div_init) begin
            r_reg    <= sq_reg >> 8;
            low_reg  <= {sq_reg[7:0], 24'd0};
            quo_reg  <= '0;
            it_reg   <= '0;
            root_reg <= '0;
            rem_reg  <= '0;
            if (zero_reg || d_reg == '0) begin
                res_reg <= '0;
            end else begin
                res_reg <= '1;
            end
        end
        if (cmd.div_step) begin
            r_reg   <= r_ge ? r_sub[D_W-1:0] : r_shift[D_W-1:0];
            quo_reg <= {quo_reg[QUO_W-2:0], r_ge};
            low_reg <= {low_reg[QUO_W-2:0], 1'b0};
            it_reg  <= it_reg + IT_W'(1);
        end
        if (cmd.sqrt_step) begin
            rem_reg  <= sq_ge ? rem_sub[REM_W-1:0] : rem4[REM_W-1:0];
            root_reg <= root_new;
            res_reg  <= root_new;
            quo_reg  <= {quo_reg[QUO_W-3:0], 2'b00};
            it_reg   <= it_reg + IT_W'(1);
        end
    end

    always_comb begin
        sts.more        = (emt_reg < limit) && (cnt_reg < BURST_W'(MAX_BURST));
        sts.bypass      = bypass;
        sts.last_row    = last_reg;
        sts.acc_last    = ({1'b0, t_reg} + 8'd1 == {1'b0, end_reg});
        // A frame at or below its mean, a flat window, or a quotient of 2^32 or more.
        sts.early       = zero_reg || (d_reg == '0) || ((sq_reg >> 8) >= d_reg);
        sts.it_done_div = (it_reg == DIV_LAST);
        sts.it_done_sq  = (it_reg == SQ_LAST);
        sts.out_free    = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign out_data = out_data_reg;
    assign out_last = out_last_reg;

    a_emt_le_rcv: assert property (@(posedge aclk) disable iff (!aresetn)
        emt_reg <= rcv_reg)
        else $error("emitted count passed received count");
    a_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (rcv_reg - emt_reg) <= CNT_W'(MAX_BURST))
        else $error("more than a burst of frames pending");
    a_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit |=> cnt_reg <= BURST_W'(MAX_BURST))
        else $error("burst counter overran");

endmodule

// ===== rtl/sliding_window_row_whitener_unit.sv =====
// A bypass word is checked, loaded raw from the buffer and emitted; a whitened frame
// runs check, setup, n buffer reads (n = window size), drain, three products, division
// setup, 32 division and 16 square root steps, emit; a flat frame, one at or below its
// mean, or one whose quotient reaches 2^32 skips division and square root.
// Frames run one at a time; a new word is accepted only after the previous word's frames.
// Reset (aresetn, sync) clears state, counters, last flag, window_len, out valid only.
module sliding_window_row_whitener_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] magnitude
    input  logic        s_tlast,   // last_in_row
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] whitened
    output logic        m_tlast,   // end_of_row
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import swrw_pkg::*;

    logic [WIN_W-1:0] window_len_reg;
    cmd_t cmd;
    sts_t sts;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= '0;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            window_len_reg <= pwdata[WIN_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {26'd0, window_len_reg};

    swrw_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swrw_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .window_len (window_len_reg),
        .in_sample  (s_tdata),
        .in_last    (s_tlast),
        .cmd        (cmd),
        .sts        (sts),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

// ===== dv/sliding_window_row_whitener_unit_test.sv =====
// Self-checking testbench for sliding_window_row_whitener_unit: streams rows of samples,
// predicts every whitened word in place and compares it with the block's output.
// Depends on the RTL top level and swrw_pkg only.
`timescale 1ns / 100ps

module sliding_window_row_whitener_unit_test;
    import swrw_pkg::*;

    typedef struct packed {
        logic [15:0] mag;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic [15:0] whitened;
        logic        eor;
    } white_t;

    localparam int LIMIT      = 1000000;
    localparam int HOLD_LEN   = 3000;
    localparam logic [2:0] WIN_ADDR = 3'd0;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;

    sliding_window_row_whitener_unit dut (.*);

    initial forever #6 aclk = ~aclk;

    sample_t pending_q[$];
    white_t  want_q[$];
    int      n_sent = 0, n_taken = 0;
    int      n_err = 0;
    int      cyc = 0;
    bit      quiet = 0;
    int      hold_asks = 0;

    // Shadow of the block: configuration, row buffer and counts.
    logic [5:0]  win_shadow = 0;
    logic [15:0] row_buf [64];
    int          rcv_cnt = 0, emt_cnt = 0;

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] zscore(int f, int half, int total);
        int start, stop;
        logic [127:0] s, q, n, x, num, d, quo;
        longint unsigned r;
        start = (f > half) ? f - half : 0;
        stop = f + half + 1;
        if (stop > total) stop = total;
        n = stop - start;
        s = 0;
        q = 0;
        for (int t = start; t < stop; t++) begin
            s += row_buf[t & 63];
            q += row_buf[t & 63] * row_buf[t & 63];
        end
        x = row_buf[f & 63];
        if (n * x <= s) return 16'd0;
        num = n * x - s;
        d = n * q - s * s;
        if (d == 0) return 16'd0;
        quo = ((num * num) << 24) / d;
        r = int_sqrt(quo[63:0]);
        return (r > 65535) ? 16'hFFFF : r[15:0];
    endfunction

    function automatic void whiten_predict(sample_t it);
        int  w, half, limit, cnt;
        bit  bypass;
        white_t o;
        w = win_shadow;
        bypass = (w <= 1);
        half = bypass ? 0 : w / 2;
        cnt = 0;
        if (emt_cnt >= 96) begin
            emt_cnt -= 64;
            rcv_cnt -= 64;
        end
        row_buf[rcv_cnt & 63] = it.mag;
        rcv_cnt = (rcv_cnt + 1) & 127;
        if (it.last) limit = rcv_cnt;
        else limit = (rcv_cnt > half) ? rcv_cnt - half : 0;
        while (emt_cnt < limit && cnt < 32) begin
            o.whitened = bypass ? row_buf[emt_cnt & 63] : zscore(emt_cnt, half, rcv_cnt);
            o.eor = it.last && (emt_cnt + 1 == rcv_cnt);
            want_q.push_back(o);
            emt_cnt++;
            cnt++;
        end
        if (it.last) begin
            rcv_cnt = 0;
            emt_cnt = 0;
        end
    endfunction

    // Monitor: input acceptance feeds the predictor, output words are checked.
    always @(posedge aclk) begin
        white_t w;
        cyc <= cyc + 1;
        if (cyc > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
        if (aresetn && s_tvalid && s_tready) begin
            whiten_predict('{mag: s_tdata, last: s_tlast});
            n_taken <= n_taken + 1;
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (want_q.size() == 0) begin
                $error("unexpected word: whitened %0d end_of_row %0d", m_tdata, m_tlast);
                n_err++;
            end else begin
                w = want_q.pop_front();
                if (m_tdata !== w.whitened) begin
                    $error("whitened: expected %0d actual %0d", w.whitened, m_tdata);
                    n_err++;
                end
                if (m_tlast !== w.eor) begin
                    $error("end_of_row: expected %0d actual %0d", w.eor, m_tlast);
                    n_err++;
                end
            end
        end
    end

    // Driver: presents the next queued sample once the current one is taken.
    int gap_left = 0;
    always @(negedge aclk) begin
        sample_t it;
        logic v;
        v = s_tvalid;
        if (aresetn && (!s_tvalid || n_taken == n_sent)) begin
            v = 0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                gap_left = $urandom_range(1, 6) - 1;
            end else if (pending_q.size() > 0) begin
                it = pending_q.pop_front();
                v = 1;
                s_tdata <= it.mag;
                s_tlast <= it.last;
                n_sent <= n_sent + 1;
            end
        end
        s_tvalid <= v;
    end

    // Receiver: random stall bursts, plus a long hold-off on request.
    int stall_left = 0, hold_left = 0, holds_done = 0;
    always @(negedge aclk) begin
        logic r;
        r = 1;
        if (hold_left > 0) begin
            hold_left--;
            r = 0;
        end else if (holds_done != hold_asks) begin
            holds_done++;
            hold_left = HOLD_LEN;
            r = 0;
        end else if (stall_left > 0) begin
            stall_left--;
            r = 0;
        end else if (!quiet && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(1, 6) - 1;
            r = 0;
        end
        m_tready <= r;
    end

    task automatic set_window(logic [5:0] w);
        @(negedge aclk);
        psel <= 1;
        pwrite <= 1;
        penable <= 0;
        paddr <= WIN_ADDR;
        pwdata <= {$urandom} & ~32'h3F | w;
        @(negedge aclk);
        penable <= 1;
        @(negedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        win_shadow = w;
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && n_taken == n_sent && want_q.size() == 0);
        repeat (400) @(posedge aclk);
    endtask

    task automatic push_row(int len, int kind);
        sample_t it;
        logic [15:0] c;
        c = 16'($urandom);
        for (int i = 0; i < len; i++) begin
            case (kind)
                0: it.mag = 16'($urandom);
                1: it.mag = c;
                2: it.mag = ($urandom_range(0, 1)) ? 16'hFFFF : 16'h0000;
                default: it.mag = 16'($urandom_range(0, 64));
            endcase
            it.last = (i == len - 1);
            pending_q.push_back(it);
        end
    endtask

    task automatic push_word(logic [15:0] m, logic l);
        pending_q.push_back('{mag: m, last: l});
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1;

        // Bypass at reset value, one-sample row and extreme samples.
        push_word(16'hFFFF, 0);
        push_word(16'h0000, 0);
        push_word(16'h1234, 1);
        push_word(16'hFFFF, 1);
        wait_idle();
        set_window(6'd1);
        push_word(16'h0001, 0);
        push_word(16'h8000, 1);
        wait_idle();
        // Zero spread, an outlier among zeros and a one-sample row with a real window.
        set_window(6'd5);
        push_row(4, 1);
        push_word(16'hFFFF, 0);
        push_word(16'h0000, 0);
        push_word(16'h0000, 0);
        push_word(16'h0000, 0);
        push_word(16'h0000, 1);
        push_word(16'h7777, 1);
        wait_idle();
        // Widest window on short rows: the window is cut at both edges.
        set_window(6'd63);
        push_row(5, 2);
        push_word(16'h0000, 0);
        push_word(16'hFFFF, 1);
        wait_idle();

        // Receiver holds off while a long row is queued at the sender.
        set_window(6'd4);
        hold_asks++;
        push_row(40, 0);
        wait_idle();
        // Long row crosses the count wrap.
        set_window(6'd2);
        push_row(150, 3);
        wait_idle();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 10) quiet = 1;
            case (ph)
                0: set_window(6'd63);
                1: set_window(6'd0);
                2: set_window(6'd3);
                default: set_window(6'($urandom_range(0, 63)));
            endcase
            for (int r = 0; r < 3; r++)
                push_row($urandom_range(1, 8), $urandom_range(0, 3));
            wait_idle();
        end

        if (n_err == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/swrw_pkg.sv
rtl/swrw_ctrl.sv
rtl/swrw_dp.sv
rtl/sliding_window_row_whitener_unit.sv
dv/sliding_window_row_whitener_unit_test.sv
